// File: rtl/core/hevc_pps_syntax_parser_defines.svh
// Assertion macros for the PPS parser.
`ifndef HEVC_PPS_SYNTAX_PARSER_DEFINES_SVH
`define HEVC_PPS_SYNTAX_PARSER_DEFINES_SVH

// Implication checked on every clock while out of reset.
`define HPP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked while out of reset.
`define HPP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/hpp_pkg.sv
package hpp_pkg;

  localparam int unsigned CodeW = 6;
  localparam int unsigned IdxW = 5;
  localparam int unsigned ValW = 33;
  localparam int unsigned StatW = 3;
  localparam int unsigned PosW = 7;
  localparam int unsigned LastCode = 52;
  localparam int unsigned TsSizeMax = 3;
  localparam int unsigned ChromaLenMax = 5;
  localparam int unsigned SaoScaleMax = 6;
  localparam int unsigned TileLimitCap = 32;
  localparam int unsigned GolombZeroLimit = 32;
  localparam int unsigned RefLimitReset = 14;
  localparam int unsigned TileLimitReset = 20;
  localparam int unsigned CfgDataW = 6;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned OutQueueDepth = 16;

  localparam logic [CfgIdxW-1:0] RegRefLimit = 1'd0;
  localparam logic [CfgIdxW-1:0] RegTileLimit = 1'd1;

  typedef enum logic [2:0] {
    StElem  = 3'd0,
    StDone  = 3'd1,
    StTrunc = 3'd2,
    StRange = 3'd3,
    StUnsup = 3'd4,
    StOvf   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    KindUe   = 2'd0,
    KindSe   = 2'd1,
    KindFlag = 2'd2,
    KindFix  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] rbsp_byte;
    logic       first_byte;
    logic       final_byte;
  } in_word_t;

  typedef struct packed {
    logic [CodeW-1:0] element_code;
    logic [IdxW-1:0]  element_index;
    logic [ValW-1:0]  element_value;
    logic [StatW-1:0] status;
    logic             last_result;
  } out_word_t;

  function automatic kind_e kind_of(logic [PosW-1:0] pos);
    kind_e k;
    unique case (pos)
      7'd0, 7'd1, 7'd7, 7'd8, 7'd13, 7'd22, 7'd23, 7'd25, 7'd26, 7'd36,
      7'd44, 7'd47, 7'd48, 7'd51, 7'd52: k = KindUe;
      7'd9, 7'd14, 7'd15, 7'd32, 7'd33, 7'd49, 7'd50: k = KindSe;
      7'd4, 7'd43: k = KindFix;
      default: k = KindFlag;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] fixed_len(logic [PosW-1:0] pos);
    logic [4:0] n;
    unique case (pos)
      7'd4: n = 5'd3;
      7'd43: n = 5'd4;
      default: n = 5'd1;
    endcase
    return n;
  endfunction

endpackage

// File: rtl/core/hpp_front.sv
module hpp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  hpp_pkg::in_word_t  in_word_i,
  output logic               q_valid_o,
  input  logic               q_ready_i,
  output hpp_pkg::in_word_t  q_word_o
);

  localparam int unsigned PtrW = $clog2(hpp_pkg::QueueDepth);

  hpp_pkg::in_word_t mem_q [hpp_pkg::QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic            active_q, active_d;
  logic            push, keep, pop;

  assign in_ready_o = cnt_q != (PtrW+1)'(hpp_pkg::QueueDepth);
  assign keep = in_word_i.first_byte || active_q;
  assign push = in_valid_i && in_ready_o && keep;
  assign pop = q_valid_o && q_ready_i;
  assign q_valid_o = cnt_q != '0;
  assign q_word_o = mem_q[rd_q];

  always_comb begin
    wr_d = push ? wr_q + 1'b1 : wr_q;
    rd_d = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    active_d = active_q;
    if (in_valid_i && in_ready_o && in_word_i.first_byte) begin
      active_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
      active_q <= 1'b0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_word_i;
    end
  end

endmodule

// File: rtl/core/hpp_back.sv
module hpp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [3:0]          ref_limit_i,
  input  logic [5:0]          tile_limit_i,
  input  logic                q_valid_i,
  output logic                q_ready_o,
  input  hpp_pkg::in_word_t   q_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hpp_pkg::out_word_t  out_word_o,
  output logic                busy_o
);

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhRun  = 2'd1;
  localparam logic [1:0] PhStop = 2'd2;
  localparam int unsigned OPtrW = $clog2(hpp_pkg::OutQueueDepth);
  localparam logic [hpp_pkg::PosW-1:0] LastPos = hpp_pkg::PosW'(hpp_pkg::LastCode);

  hpp_pkg::out_word_t omem_q [hpp_pkg::OutQueueDepth];
  logic [OPtrW-1:0] owr_q, owr_d, ord_q, ord_d;
  logic [OPtrW:0]   ocnt_q, ocnt_d;

  logic [1:0]  phase_q, phase_d;
  logic [hpp_pkg::PosW-1:0] pos_q, pos_d;
  logic [5:0]  lz_q, lz_d;
  logic [31:0] acc_q, acc_d;
  logic [4:0]  left_q, left_d;
  logic [2:0]  bf_q, bf_d;
  logic [4:0]  tcol_q, tcol_d, trow_q, trow_d, lc_q, lc_d;
  logic [2:0]  clen_q, clen_d;
  logic [7:0]  byte_q, byte_d;
  logic [2:0]  bit_q, bit_d;
  logic        fin_q, fin_d, busy_q, busy_d;
  logic        pend_q, pend_d;

  hpp_pkg::out_word_t ow;
  logic        emit, emit2, stop, bit_v;
  hpp_pkg::out_word_t ow2;
  logic        fin_el, fixk, mark_last;
  logic [31:0] raw, acc_sh;
  logic [32:0] sv;
  logic [hpp_pkg::PosW-1:0] nx;
  logic [4:0]  idx, lc_inc;
  logic        done, oor;
  logic [5:0]  tl;
  hpp_pkg::kind_e k;
  logic        room, last_bit;

  assign room = ocnt_q <= (OPtrW+1)'(hpp_pkg::OutQueueDepth - 2);
  assign q_ready_o = !busy_q;
  assign busy_o = busy_q || ocnt_q != '0;
  assign out_valid_o = ocnt_q > (OPtrW+1)'(pend_q);
  assign out_word_o = omem_q[ord_q];

  function automatic logic [hpp_pkg::PosW-1:0] step_pos(
      logic [hpp_pkg::PosW-1:0] p);
    return p + 1'b1;
  endfunction

  always_comb begin
    phase_d = phase_q; pos_d = pos_q; lz_d = lz_q; acc_d = acc_q;
    left_d = left_q; bf_d = bf_q; tcol_d = tcol_q; trow_d = trow_q;
    lc_d = lc_q; clen_d = clen_q; byte_d = byte_q; bit_d = bit_q;
    fin_d = fin_q; busy_d = busy_q; pend_d = pend_q; mark_last = 1'b0;
    emit = 1'b0; emit2 = 1'b0; stop = 1'b0;
    ow = '0; ow2 = '0;
    fin_el = 1'b0; raw = '0; sv = '0; nx = step_pos(pos_q); done = 1'b0; oor = 1'b0;
    k = hpp_pkg::kind_of(pos_q);
    fixk = (k == hpp_pkg::KindFlag) || (k == hpp_pkg::KindFix);
    idx = (pos_q == 7'd25 || pos_q == 7'd26 || pos_q == 7'd49 || pos_q == 7'd50)
          ? lc_q : 5'd0;
    tl = (tile_limit_i > 6'd32) ? 6'd32 : tile_limit_i;
    bit_v = byte_q[bit_q];
    acc_sh = {acc_q[30:0], bit_v};
    lc_inc = lc_q + 5'd1;
    last_bit = bit_q == 3'd0;

    if (q_valid_i && q_ready_o) begin
      byte_d = q_word_i.rbsp_byte;
      bit_d = 3'd7;
      fin_d = q_word_i.final_byte;
      busy_d = 1'b1;
      if (q_word_i.first_byte) begin
        phase_d = PhRun; pos_d = '0; bf_d = '0; tcol_d = '0; trow_d = '0;
        lc_d = '0; clen_d = '0; lz_d = '0; acc_d = '0; left_d = '0;
      end
      if (!(q_word_i.first_byte || phase_q == PhRun)) begin
        busy_d = 1'b0;
      end
    end else if (busy_q && room) begin
      if (fixk) begin
        acc_d = acc_sh;
        if (left_q > 5'd1) begin
          left_d = left_q - 5'd1;
        end else begin
          fin_el = 1'b1; raw = acc_sh;
        end
      end else if (left_q == 5'd0) begin
        if (!bit_v) begin
          lz_d = lz_q + 6'd1;
          if (lz_q + 6'd1 >= 6'(hpp_pkg::GolombZeroLimit)) begin
            emit = 1'b1; stop = 1'b1;
            ow.element_code = pos_q[5:0]; ow.element_index = idx;
            ow.status = hpp_pkg::StOvf;
          end
        end else if (lz_q == 6'd0) begin
          fin_el = 1'b1; raw = '0;
        end else begin
          left_d = lz_q[4:0]; acc_d = 32'd1; lz_d = '0;
        end
      end else begin
        acc_d = acc_sh;
        left_d = left_q - 5'd1;
        if (left_q == 5'd1) begin
          fin_el = 1'b1; raw = acc_sh - 32'd1;
        end
      end

      if (fin_el) begin
        if (k == hpp_pkg::KindSe) begin
          sv = raw[0] ? {1'b0, 1'b0, raw[31:1]} + 33'd1 : -{2'b00, raw[31:1]};
        end else begin
          sv = {1'b0, raw};
        end
        unique case (pos_q)
          7'd7, 7'd8: oor = raw > {28'd0, ref_limit_i};
          7'd22, 7'd23: oor = raw >= {26'd0, tl};
          7'd44: oor = raw > 32'(hpp_pkg::TsSizeMax);
          7'd48: oor = raw > 32'(hpp_pkg::ChromaLenMax);
          7'd51, 7'd52: oor = raw > 32'(hpp_pkg::SaoScaleMax);
          default: oor = 1'b0;
        endcase
        emit = 1'b1;
        ow.element_code = pos_q[5:0]; ow.element_index = idx; ow.element_value = sv;
        if (oor) begin
          ow.status = hpp_pkg::StRange; stop = 1'b1;
        end else if (pos_q == 7'd34 && raw != '0) begin
          ow.status = hpp_pkg::StUnsup; stop = 1'b1;
        end else begin
          ow.status = hpp_pkg::StElem;
          unique case (pos_q)
            7'd11: if (raw != '0) bf_d[1] = 1'b1;
            7'd12: nx = (raw != '0) ? 7'd13 : 7'd14;
            7'd20: if (raw != '0) bf_d[0] = 1'b1;
            7'd21: nx = bf_q[0] ? 7'd22 : 7'd28;
            7'd22: tcol_d = raw[4:0];
            7'd23: trow_d = raw[4:0];
            7'd24: begin
              lc_d = '0;
              if (raw != '0) nx = 7'd27;
              else if (tcol_q != '0) nx = 7'd25;
              else if (trow_q != '0) nx = 7'd26;
              else nx = 7'd27;
            end
            7'd25: begin
              if (lc_inc < tcol_q) begin
                lc_d = lc_inc; nx = 7'd25;
              end else begin
                lc_d = '0; nx = (trow_q != '0) ? 7'd26 : 7'd27;
              end
            end
            7'd26: begin
              if (lc_inc < trow_q) begin
                lc_d = lc_inc; nx = 7'd26;
              end else begin
                lc_d = '0; nx = 7'd27;
              end
            end
            7'd29: nx = (raw != '0) ? 7'd30 : 7'd34;
            7'd31: nx = (raw != '0) ? 7'd34 : 7'd32;
            7'd38: if (raw == '0) done = 1'b1;
            7'd39: if (raw != '0) bf_d[2] = 1'b1;
            7'd43: begin
              if (!bf_q[2]) done = 1'b1;
              else nx = bf_q[1] ? 7'd44 : 7'd45;
            end
            7'd46: nx = (raw != '0) ? 7'd47 : 7'd51;
            7'd48: begin
              clen_d = raw[2:0]; lc_d = '0;
            end
            7'd50: begin
              if (lc_inc <= {2'b00, clen_q}) begin
                lc_d = lc_inc; nx = 7'd49;
              end else begin
                lc_d = '0; nx = 7'd51;
              end
            end
            default: ;
          endcase
          if (pos_q == LastPos) done = 1'b1;
          if (done || nx > LastPos) begin
            emit2 = 1'b1; stop = 1'b1;
            ow2.status = hpp_pkg::StDone;
          end else begin
            pos_d = nx; lz_d = '0; acc_d = '0;
            left_d = hpp_pkg::fixed_len(nx);
            if (hpp_pkg::kind_of(nx) == hpp_pkg::KindUe
                || hpp_pkg::kind_of(nx) == hpp_pkg::KindSe) begin
              left_d = '0;
            end
          end
        end
      end

      if (stop) begin
        phase_d = PhStop; busy_d = 1'b0;
      end else if (last_bit) begin
        busy_d = 1'b0;
        if (fin_q) begin
          phase_d = PhStop;
          if (emit) begin
            emit2 = 1'b1;
            ow2.element_code = pos_d[5:0];
            ow2.element_index = (pos_d == 7'd25 || pos_d == 7'd26 || pos_d == 7'd49
                                 || pos_d == 7'd50) ? lc_d : 5'd0;
            ow2.status = hpp_pkg::StTrunc;
          end else begin
            emit = 1'b1;
            ow.element_code = pos_d[5:0];
            ow.element_index = (pos_d == 7'd25 || pos_d == 7'd26 || pos_d == 7'd49
                                || pos_d == 7'd50) ? lc_d : 5'd0;
            ow.status = hpp_pkg::StTrunc;
          end
        end
      end else begin
        bit_d = bit_q - 3'd1;
      end
      if (!busy_d) begin
        if (emit2) ow2.last_result = 1'b1;
        else if (emit) ow.last_result = 1'b1;
        else mark_last = pend_q;
      end
      pend_d = busy_d && (pend_q || emit || emit2);
    end
    if (q_valid_i && q_ready_o) begin
      left_d = q_word_i.first_byte ? hpp_pkg::fixed_len('0) : left_d;
      if (q_word_i.first_byte) left_d = '0;
    end
    owr_d = owr_q + OPtrW'(emit) + OPtrW'(emit2);
    ord_d = (out_valid_o && out_ready_i) ? ord_q + 1'b1 : ord_q;
    ocnt_d = ocnt_q + (OPtrW+1)'(emit) + (OPtrW+1)'(emit2)
             - (OPtrW+1)'(out_valid_o && out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle; pos_q <= '0; lz_q <= '0; acc_q <= '0; left_q <= '0;
      bf_q <= '0; tcol_q <= '0; trow_q <= '0; lc_q <= '0; clen_q <= '0;
      bit_q <= '0; fin_q <= 1'b0; busy_q <= 1'b0; pend_q <= 1'b0;
      owr_q <= '0; ord_q <= '0; ocnt_q <= '0;
    end else begin
      phase_q <= phase_d; pos_q <= pos_d; lz_q <= lz_d; acc_q <= acc_d;
      left_q <= left_d; bf_q <= bf_d; tcol_q <= tcol_d; trow_q <= trow_d;
      lc_q <= lc_d; clen_q <= clen_d; bit_q <= bit_d; fin_q <= fin_d;
      busy_q <= busy_d; pend_q <= pend_d;
      owr_q <= owr_d; ord_q <= ord_d; ocnt_q <= ocnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    if (emit) begin
      omem_q[owr_q] <= ow;
    end
    if (emit2) begin
      omem_q[emit ? owr_q + 1'b1 : owr_q] <= ow2;
    end
    if (mark_last) begin
      omem_q[owr_q - 1'b1].last_result <= 1'b1;
    end
  end

endmodule

// File: rtl/core/hevc_pps_syntax_parser.sv
// H.265 picture parameter set parser. Bytes enter through a four-word queue
// and are parsed one bit per clock; each completed syntax element leaves as
// one output word through a sixteen-word result queue. The newest word of a
// byte stays hidden until the byte is finished, so that its last flag is
// known, and bit parsing pauses while fewer than two result entries are free.
// The user sets ref index and tile count limits over the configuration channel
// while the block is idle; the block itself does not enforce this.
`include "hevc_pps_syntax_parser_defines.svh"

module hevc_pps_syntax_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rbsp_byte
  input  logic        s_axis_tuser,   // first_byte
  input  logic        s_axis_tlast,   // final_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // element_code, element_index, element_value, status
  output logic        m_axis_tlast,   // last_result
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [hpp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hpp_pkg::CfgDataW-1:0] cfg_data_i
);

  logic [3:0] ref_limit_q;
  logic [5:0] tile_limit_q;
  hpp_pkg::in_word_t  in_word, q_word;
  hpp_pkg::out_word_t out_word;
  logic q_valid, q_ready, busy;

  assign cfg_ready_o = 1'b1;
  assign in_word.rbsp_byte = s_axis_tdata;
  assign in_word.first_byte = s_axis_tuser;
  assign in_word.final_byte = s_axis_tlast;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_limit_q <= 4'(hpp_pkg::RefLimitReset);
      tile_limit_q <= 6'(hpp_pkg::TileLimitReset);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        hpp_pkg::RegRefLimit: ref_limit_q <= cfg_data_i[3:0];
        hpp_pkg::RegTileLimit: tile_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  hpp_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_word_i(in_word),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_word_o(q_word)
  );

  hpp_back u_back (
    .clk_i, .rst_ni,
    .ref_limit_i(ref_limit_q), .tile_limit_i(tile_limit_q),
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_word_i(q_word),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_word_o(out_word), .busy_o(busy)
  );

  assign m_axis_tdata = {1'b0, out_word.status, out_word.element_value,
                         out_word.element_index, out_word.element_code};
  assign m_axis_tlast = out_word.last_result;

  `HPP_ASSERT_IMPL(a_out_status, clk_i, rst_ni, m_axis_tvalid,
                   out_word.status <= 3'd5)
  `HPP_ASSERT_IMPL(a_busy_out, clk_i, rst_ni, m_axis_tvalid, busy)

endmodule
